// File: sv/assert_macros.svh
// Assertion macros shared by the checker file.
// Clock and reset default to clk_i / rst_ni of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ECAL_ASSERT_CR(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (prop)) else $error(msg);

// Same, on the default clock and reset.
`define ECAL_ASSERT(lbl, prop, msg) \
  `ECAL_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: sv/ecal_pkg.sv
// Package for the epoch seconds to calendar converter.
// Constants, calendar helper functions. No dependencies.
`timescale 1ns / 1ps

package ecal_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned DayQW  = 16;  // whole days fit 16 bits (max 49710)
  localparam int unsigned TodW   = 17;  // seconds of day, < 86400
  localparam int unsigned RestW  = 12;  // seconds of hour, < 3600
  localparam int unsigned YearW  = 12;

  localparam logic [DataW-1:0] SecsPerDay  = 32'd86400;
  localparam logic [DataW-1:0] SecsPerHour = 32'd3600;
  localparam logic [DataW-1:0] SecsPerMin  = 32'd60;

  // Constant divides by reciprocal multiply: q = ((x >> Shift) * Recip) >> RecipSh.
  // Each reciprocal is exact over the full operand range it sees.
  localparam int unsigned DayShift    = 7;               // 86400 = 675 << 7
  localparam int unsigned DayRecipSh  = 35;
  localparam logic [25:0] DayRecip    = 26'd50903317;    // ceil(2^35 / 675)
  localparam int unsigned HourShift   = 4;               // 3600 = 225 << 4
  localparam int unsigned HourRecipSh = 21;
  localparam logic [13:0] HourRecip   = 14'd9321;        // ceil(2^21 / 225)
  localparam int unsigned MinShift    = 2;               // 60 = 15 << 2
  localparam int unsigned MinRecipSh  = 14;
  localparam logic [10:0] MinRecip    = 11'd1093;        // ceil(2^14 / 15)

  localparam logic [YearW-1:0] FirstYear = 12'd2018;
  localparam logic [YearW-1:0] LastYear  = 12'd2154;

  // Reachable years are 2018..2154; 2100 is the only century in that span.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic quad;
    quad    = (y[1:0] == 2'b00);
    is_leap = quad && (y != 12'd2100);
  endfunction

  // Month length, mon is 0 for January
  function automatic logic [8:0] month_len(input logic [3:0] mon, input logic leap);
    logic [8:0] len;
    case (mon)
      4'd1:                             len = leap ? 9'd29 : 9'd28;
      4'd3, 4'd5, 4'd8, 4'd10:          len = 9'd30;
      default:                          len = 9'd31;
    endcase
    month_len = len;
  endfunction

endpackage

// File: sv/ecal_sub_unit.sv
// Shared subtract/compare unit of the calendar converter.
// Depends on ecal_pkg.
`timescale 1ns / 1ps

module ecal_sub_unit import ecal_pkg::*; (
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output logic [DataW-1:0] diff_o,
  output logic             ge_o
);

  logic [DataW:0] full;

  // borrow out clear means a >= b
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[DataW-1:0];
  assign ge_o   = ~full[DataW];

endmodule

// File: sv/epoch_seconds_to_calendar.sv
// Top level: running seconds counter plus base to Gregorian date and time.
// Depends on ecal_pkg and ecal_sub_unit.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+--------------------------------
//   in       | in_valid_i / in_ready_o      | counter_value_i
//   out      | out_valid_o / out_ready_i    | year_o month_o day_o hour_o
//            |                              |   minute_o second_o
//   config   | base_seconds_we_i            | base_seconds_i
//
// One word passes through accept, three reciprocal divides (86400, 3600, 60)
// of a multiply state and a remainder state each, the year walk, the month
// walk and the output load. Every subtract/compare goes through the one
// shared unit. in_ready_o is high only in IDLE; a finished word parks in the
// output register so the next word can be taken while the result waits.
// Reset clears base_seconds, the sequencer and output valid.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar import ecal_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             base_seconds_we_i,
  input  logic [DataW-1:0] base_seconds_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] counter_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [YearW-1:0] year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_o,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o
);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StDay     = 4'd1;  // total / 86400
  localparam logic [3:0] StDayRem  = 4'd2;  // tod = total - days * 86400
  localparam logic [3:0] StHour    = 4'd3;  // tod / 3600
  localparam logic [3:0] StHourRem = 4'd4;  // rest = tod - hour * 3600
  localparam logic [3:0] StMin     = 4'd5;  // rest / 60
  localparam logic [3:0] StMinRem  = 4'd6;  // sec = rest - min * 60
  localparam logic [3:0] StYear    = 4'd7;  // year walk
  localparam logic [3:0] StMon     = 4'd8;  // month walk
  localparam logic [3:0] StDone    = 4'd9;  // wait for output slot

  logic [3:0]       state_q, state_d;
  logic [DataW-1:0] base_q;
  logic [DataW-1:0] acc_q, acc_d;      // running remainder
  logic [DayQW-1:0] days_q, days_d;
  logic [4:0]       hour_q, hour_d;
  logic [5:0]       min_q, min_d;
  logic [YearW-1:0] year_q, year_d;
  logic [3:0]       mon_q, mon_d;

  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic [YearW-1:0] year_out_q;
  logic [3:0]       month_out_q;
  logic [4:0]       day_out_q;
  logic [4:0]       hour_out_q;
  logic [5:0]       minute_out_q;
  logic [5:0]       second_out_q;

  // reciprocal products
  logic [50:0]      day_prod;   // 25 x 26 bits
  logic [26:0]      hour_prod;  // 13 x 14 bits
  logic [20:0]      min_prod;   // 10 x 11 bits

  // shared unit operands
  logic [DataW-1:0] su_a, su_b, su_diff;
  logic             su_ge;
  logic             leap;
  logic             in_fire;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign leap       = is_leap(year_q);

  assign day_prod  = acc_q[DataW-1:DayShift] * DayRecip;
  assign hour_prod = acc_q[TodW-1:HourShift] * HourRecip;
  assign min_prod  = acc_q[RestW-1:MinShift] * MinRecip;

  always_comb begin
    su_a = acc_q;
    su_b = '0;
    unique case (state_q)
      StDayRem:  su_b = {{(DataW-DayQW){1'b0}}, days_q} * SecsPerDay;
      StHourRem: su_b = {{(DataW-5){1'b0}}, hour_q} * SecsPerHour;
      StMinRem:  su_b = {{(DataW-6){1'b0}}, min_q} * SecsPerMin;
      StYear: begin
        su_a = {{(DataW-DayQW){1'b0}}, days_q};
        su_b = leap ? 32'd366 : 32'd365;
      end
      StMon: begin
        su_a = {{(DataW-DayQW){1'b0}}, days_q};
        su_b = {{(DataW-9){1'b0}}, month_len(mon_q, leap)};
      end
      default: begin
        su_a = acc_q;
        su_b = '0;
      end
    endcase
  end

  ecal_sub_unit u_sub (
    .a_i    (su_a),
    .b_i    (su_b),
    .diff_o (su_diff),
    .ge_o   (su_ge)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    days_d      = days_q;
    hour_d      = hour_q;
    min_d       = min_q;
    year_d      = year_q;
    mon_d       = mon_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          acc_d   = base_q + counter_value_i;  // wraps mod 2^32
          state_d = StDay;
        end
      end
      StDay: begin
        days_d  = day_prod[DayRecipSh +: DayQW];
        state_d = StDayRem;
      end
      StDayRem: begin
        acc_d   = su_diff;
        state_d = StHour;
      end
      StHour: begin
        hour_d  = hour_prod[HourRecipSh +: 5];
        state_d = StHourRem;
      end
      StHourRem: begin
        acc_d   = su_diff;
        state_d = StMin;
      end
      StMin: begin
        min_d   = min_prod[MinRecipSh +: 6];
        state_d = StMinRem;
      end
      StMinRem: begin
        acc_d   = su_diff;
        year_d  = FirstYear;
        state_d = StYear;
      end
      StYear: begin
        if (su_ge) begin
          days_d = su_diff[DayQW-1:0];
          year_d = year_q + 12'd1;
        end else begin
          mon_d   = 4'd0;
          state_d = StMon;
        end
      end
      StMon: begin
        // December takes whatever is left
        if (su_ge && (mon_q != 4'd11)) begin
          days_d = su_diff[DayQW-1:0];
          mon_d  = mon_q + 4'd1;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (base_seconds_we_i) base_q <= base_seconds_i;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    days_q <= days_d;
    hour_q <= hour_d;
    min_q  <= min_d;
    year_q <= year_d;
    mon_q  <= mon_d;
    if (out_load) begin
      year_out_q   <= year_q;
      month_out_q  <= mon_q + 4'd1;
      day_out_q    <= days_q[4:0] + 5'd1;
      hour_out_q   <= hour_q;
      minute_out_q <= min_q;
      second_out_q <= acc_q[5:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign year_o      = year_out_q;
  assign month_o     = month_out_q;
  assign day_o       = day_out_q;
  assign hour_o      = hour_out_q;
  assign minute_o    = minute_out_q;
  assign second_o    = second_out_q;

endmodule

// File: sv/ecal_checker.sv
// Port-level checker for epoch_seconds_to_calendar, bound to the top level.
// Depends on ecal_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ecal_checker import ecal_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             base_seconds_we_i,
  input logic [DataW-1:0] base_seconds_i,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [DataW-1:0] counter_value_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [YearW-1:0] year_o,
  input logic [3:0]       month_o,
  input logic [4:0]       day_o,
  input logic [4:0]       hour_o,
  input logic [5:0]       minute_o,
  input logic [5:0]       second_o
);

  logic date_ok;
  logic time_ok;

  assign date_ok = month_o >= 4'd1 && month_o <= 4'd12 && day_o >= 5'd1 &&
                   year_o >= FirstYear && year_o <= LastYear;
  assign time_ok = hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59;

  `ECAL_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "out word dropped")
  `ECAL_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready while busy")
  `ECAL_ASSERT(a_date_range, out_valid_o |-> date_ok, "date out of range")
  `ECAL_ASSERT(a_time_range, out_valid_o |-> time_ok, "time out of range")

endmodule

bind epoch_seconds_to_calendar ecal_checker u_ecal_checker (.*);

// File: tb/testbench.sv
// Self-checking bench for epoch_seconds_to_calendar: seconds counter plus base to date/time.
// Needs ecal_pkg and the converter RTL. Each word's date and time are predicted
// locally and compared with the returned word.
`timescale 1ns / 1ps

module testbench;
  import ecal_pkg::*;

  // Watchdog limit, in cycles with no handshake on either channel. It sits well
  // above the slowest word plus the worst sender gap and receiver stall, and above
  // the long receiver hold and the end settle.
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned RandomWords = 55;

  // One result word, packed in port order
  typedef struct packed {
    logic [YearW-1:0] year;
    logic [3:0]       month;
    logic [4:0]       day;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
  } calendar_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             base_seconds_we_i = 1'b0;
  logic [DataW-1:0] base_seconds_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [DataW-1:0] counter_value_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [YearW-1:0] year_o;
  logic [3:0]       month_o;
  logic [4:0]       day_o;
  logic [4:0]       hour_o;
  logic [5:0]       minute_o;
  logic [5:0]       second_o;

  // Bench copy of the base register, updated whenever the bench writes it
  logic [DataW-1:0] base_shadow = '0;
  calendar_t        pending_dates[$];

  // Traffic shaping knobs, set by the test tasks
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  int unsigned rx_hold_left = 0;
  int unsigned rx_stall_left = 0;

  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned base_writes = 0;
  int unsigned stalled_cycles = 0;
  logic [YearW-1:0] year_lo = '1;
  logic [YearW-1:0] year_hi = '0;

  always #1 clk_i = ~clk_i;

  epoch_seconds_to_calendar uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .base_seconds_we_i (base_seconds_we_i),
    .base_seconds_i    (base_seconds_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .counter_value_i   (counter_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .year_o            (year_o),
    .month_o           (month_o),
    .day_o             (day_o),
    .hour_o            (hour_o),
    .minute_o          (minute_o),
    .second_o          (second_o)
  );

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Full Gregorian rule: every 4th year, centuries only when divisible by 400
  function automatic bit gregorian_leap(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // Days in month, mon counts from 0 (January)
  function automatic int unsigned days_in_month(input int unsigned mon, input bit leap);
    int unsigned len;
    len = 31;
    if (mon == 1) len = leap ? 29 : 28;
    else if (mon == 3 || mon == 5 || mon == 8 || mon == 10) len = 30;
    return len;
  endfunction

  // Base plus counter (mod 2^32) as seconds since 2018-01-01 00:00:00,
  // walked out to a calendar date and time of day.
  function automatic calendar_t to_calendar(input logic [DataW-1:0] base,
                                            input logic [DataW-1:0] count);
    logic [DataW-1:0] total;
    int unsigned      days_left;
    int unsigned      tod;
    int unsigned      yr;
    int unsigned      mon;
    int unsigned      ylen;
    bit               leap;
    calendar_t        cal;
    total     = base + count;           // wraps at 32 bits on purpose
    days_left = total / SecsPerDay;
    tod       = total % SecsPerDay;
    yr        = FirstYear;
    ylen      = gregorian_leap(yr) ? 366 : 365;
    while (days_left >= ylen) begin
      days_left -= ylen;
      yr++;
      ylen = gregorian_leap(yr) ? 366 : 365;
    end
    // December absorbs whatever is left, so the last day of a leap year
    // stays inside the same year.
    leap = gregorian_leap(yr);
    mon  = 0;
    while (mon < 11 && days_left >= days_in_month(mon, leap)) begin
      days_left -= days_in_month(mon, leap);
      mon++;
    end
    cal.year   = yr[YearW-1:0];
    cal.month  = 4'(mon + 1);
    cal.day    = 5'(days_left + 1);
    cal.hour   = 5'(tod / SecsPerHour);
    cal.minute = 6'((tod % SecsPerHour) / SecsPerMin);
    cal.second = 6'(tod % SecsPerMin);
    return cal;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, a long hold on request, or always ready
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready_i  = 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else if (rx_stall_left > 0) begin
      out_ready_i   = 1'b0;
      rx_stall_left = rx_stall_left - 1;
    end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
      out_ready_i   = 1'b0;
      rx_stall_left = $urandom_range(1, 18) - 1;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every returned word against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    calendar_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_dates.size() == 0) begin
        $error("result word with nothing expected: %0d-%0d-%0d %0d:%0d:%0d",
               year_o, month_o, day_o, hour_o, minute_o, second_o);
        errors++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year",   want.year,   year_o);
        check_field("month",  want.month,  month_o);
        check_field("day",    want.day,    day_o);
        check_field("hour",   want.hour,   hour_o);
        check_field("minute", want.minute, minute_o);
        check_field("second", want.second, second_o);
        words_checked++;
        if (year_o < year_lo) year_lo = year_o;
        if (year_o > year_hi) year_hi = year_o;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a word for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= StallLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 stalled_cycles, pending_dates.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Sends one counter word. Called at a falling edge, returns at a falling edge
  // with valid still high: the caller either sends again right away or drops
  // valid through wait_idle.
  task automatic send_word(input logic [DataW-1:0] count);
    int unsigned gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap        = $urandom_range(1, 18);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    counter_value_i = count;
    do @(posedge clk_i); while (!in_ready_o);
    pending_dates.push_back(to_calendar(base_shadow, count));
    words_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every predicted word has come back
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_dates.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Base register write, only with the converter idle
  task automatic write_base(input logic [DataW-1:0] value);
    wait_idle();
    base_seconds_we_i = 1'b1;
    base_seconds_i    = value;
    base_shadow       = value;
    base_writes++;
    @(negedge clk_i);
    base_seconds_we_i = 1'b0;
  endtask

  // Half are full-range counters; the rest land on day edges of the sum, which
  // hits month and year boundaries, or stay small.
  function automatic logic [DataW-1:0] pick_counter(input logic [DataW-1:0] base);
    logic [DataW-1:0] target;
    logic [DataW-1:0] count;
    case ($urandom_range(0, 3))
      0, 1: count = $urandom;
      2: begin
        target = $urandom_range(0, 49710) * SecsPerDay;
        if ($urandom_range(0, 1) == 1) target = target + SecsPerDay - 1;
        count = target - base;
      end
      default: count = $urandom_range(0, 255);
    endcase
    return count;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Base 0: first day, time-of-day edges, leap and non-leap year ends,
  // February 29 in 2020, the 2100 century non-leap year, and the largest sum.
  task automatic test_calendar_edges();
    write_base('0);
    send_word(32'd0);
    send_word(32'd59);
    send_word(32'd3599);
    send_word(32'd86399);
    send_word(32'd86400);
    send_word(32'd31535999);                         // 2018-12-31 23:59:59
    send_word(32'd31536000);                         // 2019-01-01
    send_word(32'd788 * SecsPerDay + 32'd86399);     // 2020-02-28 23:59:59
    send_word(32'd789 * SecsPerDay);                 // 2020-02-29
    send_word(32'd1095 * SecsPerDay);                // 2020-12-31, leap year end
    send_word(32'd1095 * SecsPerDay + 32'd86399);
    send_word(32'd1096 * SecsPerDay);                // 2021-01-01
    send_word(32'd30008 * SecsPerDay);               // 2100-02-28
    send_word(32'd30009 * SecsPerDay);               // 2100-03-01, no Feb 29
    send_word(32'd30314 * SecsPerDay + 32'd86399);   // 2100-12-31
    send_word(32'd30315 * SecsPerDay);               // 2101-01-01
    send_word(32'hFFFF_FFFF);                        // latest reachable instant
    send_word(32'h8000_0000);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
    wait_idle();
  endtask

  // Base all ones: the 32-bit sum wraps back to and around day zero
  task automatic test_sum_wrap();
    write_base('1);
    send_word(32'd1);
    send_word(32'd0);
    send_word(32'hFFFF_FFFF);
    send_word(32'd86401);
    wait_idle();
  endtask

  // Receiver holds off for a long stretch while words keep coming: the parked
  // result blocks the output, so the converter must stall its input.
  task automatic test_output_backpressure();
    write_base($urandom);
    tx_gaps      = 1'b0;
    rx_hold_left = HoldCycles;
    repeat (8) send_word(pick_counter(base_shadow));
    wait_idle();
    tx_gaps = 1'b1;
  endtask

  // Sender goes quiet until everything is back, then resumes
  task automatic test_sender_pause();
    repeat (5) send_word(pick_counter(base_shadow));
    wait_idle();
    repeat (5) send_word(pick_counter(base_shadow));
    wait_idle();
  endtask

  // Random counters under a series of bases, extremes included
  task automatic test_random_bases();
    logic [DataW-1:0] bases[6];
    bases = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'h0};
    bases[2] = $urandom;
    bases[4] = $urandom;
    bases[5] = $urandom;
    foreach (bases[i]) begin
      write_base(bases[i]);
      repeat (RandomWords) send_word(pick_counter(base_shadow));
    end
    wait_idle();
  endtask

  // Last part: both sides run flat out
  task automatic test_streaming();
    write_base($urandom);
    tx_gaps       = 1'b0;
    rx_stalls     = 1'b0;
    rx_stall_left = 0;
    repeat (60) send_word(pick_counter(base_shadow));
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_calendar_edges();
    test_sum_wrap();
    test_output_backpressure();
    test_sender_pause();
    test_random_bases();
    test_streaming();

    // Catch any stray word after the last expected one
    repeat (SettleCycles) @(negedge clk_i);

    $display("covered %0d words (%0d checked) over %0d base settings",
             words_sent, words_checked, base_writes);
    $display("years seen %0d..%0d, %0d mismatches", year_lo, year_hi, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
